// ===== rtl/gptt_pkg.sv =====
// Shared types and constants for the gated position track table.
// Depends on nothing; the other rtl files but gptt_ram refer to it by scoped names.
package gptt_pkg;

	localparam int MAX_TRACKS_DEFAULT = 16;
	localparam int COORD_W = 16;
	localparam int RADIUS_W = 15;
	localparam int GATE_SQ_W = 2 * RADIUS_W;
	localparam int INDEX_W = 4;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QFILL_W = $clog2(QUEUE_DEPTH + 1);

	// 10.0 in Q11.4
	localparam logic [RADIUS_W-1:0] GATE_RADIUS_RESET = RADIUS_W'(160);
	localparam logic [GATE_SQ_W-1:0] GATE_SQ_RESET = GATE_SQ_W'(160 * 160);

	typedef struct packed {
		logic signed [COORD_W-1:0] det_x;
		logic signed [COORD_W-1:0] det_y;
	} det_t;

	typedef struct packed {
		logic [INDEX_W-1:0]        track_index;
		logic signed [COORD_W-1:0] avg_x;
		logic signed [COORD_W-1:0] avg_y;
		logic                      new_track;
		logic                      dropped;
	} res_t;

	// one queued job: the detection plus the squared gate in force at accept
	typedef struct packed {
		det_t                 det;
		logic [GATE_SQ_W-1:0] gate_sq;
	} job_t;

endpackage

// ===== rtl/gptt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module gptt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/gptt_queue.sv =====
// Short job queue between front and back.
// Depends on gptt_pkg.
module gptt_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  gptt_pkg::job_t push_data,
	output logic          full,
	input  logic          pop,
	output gptt_pkg::job_t pop_data,
	output logic          empty
);

	gptt_pkg::job_t                     slot_q [gptt_pkg::QUEUE_DEPTH];
	logic [gptt_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [gptt_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [gptt_pkg::QFILL_W-1:0] fill_q;

	assign full     = fill_q == gptt_pkg::QFILL_W'(gptt_pkg::QUEUE_DEPTH);
	assign empty    = fill_q == '0;
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + gptt_pkg::QPTR_W'(1);
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + gptt_pkg::QPTR_W'(1);
			end
			case ({push && !full, pop && !empty})
				2'b10:   fill_q <= fill_q + gptt_pkg::QFILL_W'(1);
				2'b01:   fill_q <= fill_q - gptt_pkg::QFILL_W'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/gptt_front.sv =====
// Front end: gate radius register, detection intake and job issue.
// Depends on gptt_pkg.
module gptt_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [gptt_pkg::RADIUS_W-1:0]  cfg_data,
	input  logic                           start,
	output logic                           busy,
	input  gptt_pkg::det_t                 det,
	output logic                           push,
	output gptt_pkg::job_t                 push_data,
	input  logic                           q_full
);

	logic [gptt_pkg::GATE_SQ_W-1:0] gate_sq_q;
	logic                           valid_s1;
	gptt_pkg::det_t                 det_s1;
	logic                           take;

	assign cfg_ready = 1'b1;
	// stage holds while the queue is full
	assign busy = valid_s1 && q_full;
	assign take = start && !busy;
	assign push = valid_s1;
	assign push_data = '{det: det_s1, gate_sq: gate_sq_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_sq_q <= gptt_pkg::GATE_SQ_RESET;
			valid_s1  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				gate_sq_q <= gptt_pkg::GATE_SQ_W'(cfg_data) *
					gptt_pkg::GATE_SQ_W'(cfg_data);
			end
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (!q_full) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			det_s1 <= det;
		end
	end

endmodule

// ===== rtl/gptt_back.sv =====
// Back end: walks the track table for one job, updates, appends or drops, emits result.
// Depends on gptt_pkg and gptt_ram.
module gptt_back #(
	parameter int MAX_TRACKS = gptt_pkg::MAX_TRACKS_DEFAULT
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	output logic                                      pop,
	input  gptt_pkg::job_t                            pop_data,
	input  logic                                      empty,
	output logic                                      done,
	output gptt_pkg::res_t                            result,
	output logic [$clog2(MAX_TRACKS + 1)-1:0]         track_cnt
);

	localparam int IDX_W = MAX_TRACKS > 1 ? $clog2(MAX_TRACKS) : 1;
	localparam int CNT_W = $clog2(MAX_TRACKS + 1);
	localparam int CW = gptt_pkg::COORD_W;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RD   = 5'b00010,
		S_SQ   = 5'b00100,
		S_CMP  = 5'b01000,
		S_UPD  = 5'b10000
	} state_t;

	state_t                         state_q;
	logic [IDX_W-1:0]               idx_q;
	logic [CNT_W-1:0]               cnt_q;
	logic                           found_q;
	gptt_pkg::det_t                 det_q;
	logic [gptt_pkg::GATE_SQ_W-1:0] gate_sq_q;
	logic signed [CW-1:0]           trk_x_q;
	logic signed [CW-1:0]           trk_y_q;
	logic [2*CW-1:0]                sqx_q;
	logic [2*CW-1:0]                sqy_q;
	logic                           done_q;
	gptt_pkg::res_t                 res_q;

	logic [2*CW-1:0]   rdata;
	logic              we;
	logic [IDX_W-1:0]  waddr;
	logic [2*CW-1:0]   wdata;
	logic signed [CW:0] dx;
	logic signed [CW:0] dy;
	logic [CW:0]       adx;
	logic [CW:0]       ady;
	logic [2*CW:0]     dist_sq;
	logic              hit;
	logic              last;
	logic              full;
	logic signed [CW:0] sum_x;
	logic signed [CW:0] sum_y;
	logic [IDX_W+3:0]  idx_ext;
	logic [CNT_W+3:0]  cnt_ext;

	gptt_ram #(
		.WIDTH(2 * CW),
		.DEPTH(MAX_TRACKS)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(idx_q),
		.rdata(rdata)
	);

	assign pop       = (state_q == S_IDLE) && !empty;
	assign done      = done_q;
	assign result    = res_q;
	assign track_cnt = cnt_q;

	// distance terms; |d| always fits 16 bits
	always_comb begin
		dx   = {det_q.det_x[CW-1], det_q.det_x} - {rdata[2*CW-1], rdata[2*CW-1:CW]};
		dy   = {det_q.det_y[CW-1], det_q.det_y} - {rdata[CW-1], rdata[CW-1:0]};
		adx  = dx[CW] ? -dx : dx;
		ady  = dy[CW] ? -dy : dy;
		dist_sq = {1'b0, sqx_q} + {1'b0, sqy_q};
		hit  = dist_sq < (2*CW+1)'(gate_sq_q);
		last = (CNT_W'(idx_q) + CNT_W'(1)) == cnt_q;
		full = cnt_q == CNT_W'(MAX_TRACKS);
		sum_x = {trk_x_q[CW-1], trk_x_q} + {det_q.det_x[CW-1], det_q.det_x};
		sum_y = {trk_y_q[CW-1], trk_y_q} + {det_q.det_y[CW-1], det_q.det_y};
		idx_ext = {4'b0, idx_q};
		cnt_ext = {4'b0, cnt_q};
	end

	// table write happens only in the update step
	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = {sum_x[CW:1], sum_y[CW:1]};
		if (state_q == S_UPD) begin
			if (found_q) begin
				we = 1'b1;
			end else if (!full) begin
				we    = 1'b1;
				waddr = cnt_q[IDX_W-1:0];
				wdata = {det_q.det_x, det_q.det_y};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			cnt_q   <= '0;
			found_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (!empty) begin
						idx_q   <= '0;
						found_q <= 1'b0;
						state_q <= (cnt_q == '0) ? S_UPD : S_RD;
					end
				end
				S_RD:  state_q <= S_SQ;
				S_SQ:  state_q <= S_CMP;
				S_CMP: begin
					if (hit) begin
						found_q <= 1'b1;
						state_q <= S_UPD;
					end else if (last) begin
						state_q <= S_UPD;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= S_RD;
					end
				end
				S_UPD: begin
					if (!found_q && !full) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			det_q     <= pop_data.det;
			gate_sq_q <= pop_data.gate_sq;
		end
		if (state_q == S_SQ) begin
			trk_x_q <= rdata[2*CW-1:CW];
			trk_y_q <= rdata[CW-1:0];
			sqx_q   <= (2*CW)'(adx[CW-1:0]) * (2*CW)'(adx[CW-1:0]);
			sqy_q   <= (2*CW)'(ady[CW-1:0]) * (2*CW)'(ady[CW-1:0]);
		end
		if (state_q == S_UPD) begin
			if (found_q) begin
				res_q <= '{track_index: idx_ext[3:0], avg_x: sum_x[CW:1],
					avg_y: sum_y[CW:1], new_track: 1'b0, dropped: 1'b0};
			end else if (!full) begin
				res_q <= '{track_index: cnt_ext[3:0], avg_x: det_q.det_x,
					avg_y: det_q.det_y, new_track: 1'b1, dropped: 1'b0};
			end else begin
				res_q <= '{track_index: '0, avg_x: det_q.det_x,
					avg_y: det_q.det_y, new_track: 1'b0, dropped: 1'b1};
			end
		end
	end

endmodule

// ===== rtl/gated_position_track_table.sv =====
// Gated position track table, top level: front, job queue, back.
// One item in the back at a time: pop, then one read/square/compare round per track
// up to and including the first hit (every stored track on a miss), then update;
// busy rises while the staged item meets a full queue.
// Reset (arst_n low, async): track table empty, gate radius 160; no clearing pass.
module gated_position_track_table #(
	parameter int MAX_TRACKS = gptt_pkg::MAX_TRACKS_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write channel: gate radius, Q11.4
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [gptt_pkg::RADIUS_W-1:0] cfg_data,
	// command side: a transfer happens when start is high and busy is low
	input  logic                          start,
	output logic                          busy,
	input  gptt_pkg::det_t                det,
	// result strobe, one cycle; the receiver cannot stall it
	output logic                          done,
	output gptt_pkg::res_t                result
);

	localparam int CNT_W = $clog2(MAX_TRACKS + 1);

	logic             push;
	gptt_pkg::job_t   push_data;
	logic             q_full;
	logic             pop;
	gptt_pkg::job_t   pop_data;
	logic             q_empty;
	logic [CNT_W-1:0] track_cnt;

	// front squares the gate once per config write and stages each detection
	gptt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.start    (start),
		.busy     (busy),
		.det      (det),
		.push     (push),
		.push_data(push_data),
		.q_full   (q_full)
	);

	// two-entry queue decouples intake from the table walk
	gptt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (q_full),
		.pop      (pop),
		.pop_data (pop_data),
		.empty    (q_empty)
	);

	// back walks stored tracks in index order, first hit inside the gate wins
	gptt_back #(
		.MAX_TRACKS(MAX_TRACKS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop      (pop),
		.pop_data (pop_data),
		.empty    (q_empty),
		.done     (done),
		.result   (result),
		.track_cnt(track_cnt)
	);

	// results are spaced by at least the update step
	a_done_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("back-to-back result strobes");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		track_cnt <= CNT_W'(MAX_TRACKS))
		else $error("track count beyond table size");

	// count moves only with a result that reports a new track
	a_cnt_move: assert property (@(posedge clk) disable iff (!arst_n)
		(track_cnt != $past(track_cnt)) |-> (done && result.new_track))
		else $error("track count changed without new track result");

	a_drop_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.dropped) |-> (!result.new_track && result.track_index == '0))
		else $error("dropped result with bad fields");

endmodule

// ===== bench/gated_position_track_table_test.sv =====
// Self-checking bench for gated_position_track_table: random and directed detections,
// gate radius rewrites between phases, every result checked against an in-bench tracker.
// Depends on rtl/gptt_pkg.sv and rtl/gated_position_track_table.sv.
`timescale 1ns / 1ps

module gated_position_track_table_test;

	localparam int TRACK_SLOTS = gptt_pkg::MAX_TRACKS_DEFAULT;
	localparam int PHASE_ITEMS = 146;
	localparam int CYCLE_LIMIT = 1000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [gptt_pkg::RADIUS_W-1:0] cfg_data = '0;
	logic start = 1'b0;
	logic busy;
	gptt_pkg::det_t det = '0;
	logic done;
	gptt_pkg::res_t result;

	gated_position_track_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.det(det),
		.done(done),
		.result(result)
	);

	// 12 ns period
	always #6 clk = ~clk;

	// Tracker mirror: table contents, fill level and the gate radius in force.
	logic signed [gptt_pkg::COORD_W-1:0] trk_x [TRACK_SLOTS];
	logic signed [gptt_pkg::COORD_W-1:0] trk_y [TRACK_SLOTS];
	int trk_count = 0;
	logic [gptt_pkg::RADIUS_W-1:0] gate_model = gptt_pkg::GATE_RADIUS_RESET;

	gptt_pkg::det_t pending_dets [$];     // detections waiting for a start transfer
	gptt_pkg::res_t awaited_results [$];  // one entry per accepted detection

	int mismatch_count = 0;
	int sent_count = 0;
	int matched_count = 0;
	int opened_count = 0;
	int dropped_count = 0;
	int gate_writes = 0;
	int cycle_count = 0;

	int hold_off = 0;     // idle cycles left before the next start
	int burst_left = 0;   // transfers left in a no-gap stretch
	int driver_gap;

	// Walk the table in index order, take the first track strictly inside the gate,
	// otherwise append, otherwise drop. Updates the mirror as the block would.
	function automatic gptt_pkg::res_t associate(input gptt_pkg::det_t d);
		gptt_pkg::res_t r;
		longint dx, dy, dsq, gate_sq, px, py, ox, oy;
		int hit;
		px = d.det_x;
		py = d.det_y;
		gate_sq = longint'(gate_model) * longint'(gate_model);
		hit = -1;
		for (int i = 0; i < trk_count; i++) begin
			ox = trk_x[i];
			oy = trk_y[i];
			dx = px - ox;
			dy = py - oy;
			dsq = dx * dx + dy * dy;
			if (dsq < gate_sq) begin
				hit = i;
				break;
			end
		end
		r = '0;
		if (hit >= 0) begin
			ox = trk_x[hit];
			oy = trk_y[hit];
			// floor average: arithmetic shift rounds toward minus infinity
			trk_x[hit] = 16'((ox + px) >>> 1);
			trk_y[hit] = 16'((oy + py) >>> 1);
			r.track_index = 4'(hit);
			r.avg_x = trk_x[hit];
			r.avg_y = trk_y[hit];
		end else if (trk_count < TRACK_SLOTS) begin
			trk_x[trk_count] = d.det_x;
			trk_y[trk_count] = d.det_y;
			r.track_index = 4'(trk_count);
			r.avg_x = d.det_x;
			r.avg_y = d.det_y;
			r.new_track = 1'b1;
			trk_count++;
		end else begin
			// table full and nothing in the gate: index 0, detection echoed
			r.avg_x = d.det_x;
			r.avg_y = d.det_y;
			r.dropped = 1'b1;
		end
		return r;
	endfunction

	function automatic logic signed [15:0] clamp16(input int v);
		if (v > 32767)
			return 16'sd32767;
		if (v < -32768)
			return -16'sd32768;
		return 16'(v);
	endfunction

	// Mostly aimed at a live track (inside the gate, near its edge, or exactly on it),
	// the rest full-range noise that sets every bit.
	function automatic gptt_pkg::det_t make_detection();
		gptt_pkg::det_t d;
		int pick, t, reach, ox, oy;
		pick = $urandom_range(0, 99);
		d.det_x = 16'($urandom);
		d.det_y = 16'($urandom);
		if (pick < 75 && trk_count > 0) begin
			t = $urandom_range(0, trk_count - 1);
			ox = trk_x[t];
			oy = trk_y[t];
			if (pick < 5) begin
				// unless the clamp cuts it, squared distance equals the squared gate and must not match
				d.det_x = clamp16(ox + gate_model);
				d.det_y = 16'(oy);
			end else begin
				reach = (pick < 55) ? (gate_model * 7) / 10 : (gate_model * 13) / 10;
				d.det_x = clamp16(ox + int'($urandom_range(0, 2 * reach)) - reach);
				d.det_y = clamp16(oy + int'($urandom_range(0, 2 * reach)) - reach);
			end
		end
		return d;
	endfunction

	// Mostly short gaps, a few long ones, and now and then a stretch with none.
	function automatic int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 49) == 0) begin
			burst_left = $urandom_range(30, 80);
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// Command driver: predict on each start transfer, then either keep start high with
	// the next detection or drop it for a gap.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				awaited_results = {awaited_results, associate(det)};
				sent_count++;
				driver_gap = pick_gap();
				if (driver_gap == 0 && pending_dets.size() > 0) begin
					det <= pending_dets.pop_front();
				end else begin
					start <= 1'b0;
					hold_off <= driver_gap;
				end
			end else if (!start) begin
				if (hold_off > 0) begin
					hold_off <= hold_off - 1;
				end else if (pending_dets.size() > 0) begin
					det <= pending_dets.pop_front();
					start <= 1'b1;
				end
			end
		end
	end

	task automatic report(input string field, input longint want, input longint got);
		mismatch_count++;
		$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
	endtask

	// Result monitor: done is a one-cycle strobe, checked against the oldest prediction.
	always @(posedge clk) begin
		gptt_pkg::res_t want;
		if (arst_n && done) begin
			if (awaited_results.size() == 0) begin
				mismatch_count++;
				$display("%0t ns: unexpected result, expected none, got index %0d x %0d y %0d",
					$time, result.track_index, result.avg_x, result.avg_y);
			end else begin
				want = awaited_results.pop_front();
				if (result.track_index !== want.track_index)
					report("track_index", want.track_index, result.track_index);
				if (result.avg_x !== want.avg_x)
					report("avg_x", want.avg_x, result.avg_x);
				if (result.avg_y !== want.avg_y)
					report("avg_y", want.avg_y, result.avg_y);
				if (result.new_track !== want.new_track)
					report("new_track", want.new_track, result.new_track);
				if (result.dropped !== want.dropped)
					report("dropped", want.dropped, result.dropped);
				if (want.dropped)
					dropped_count++;
				else if (want.new_track)
					opened_count++;
				else
					matched_count++;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("gated_position_track_table test failed");
			$finish;
		end
	end

	task automatic queue_det(input int x, input int y);
		gptt_pkg::det_t d;
		d.det_x = 16'(x);
		d.det_y = 16'(y);
		pending_dets = {pending_dets, d};
	endtask

	// Wait until every queued detection has been transferred and answered.
	task automatic drain();
		while (pending_dets.size() > 0 || start || awaited_results.size() > 0)
			@(negedge clk);
	endtask

	// Gate rewrite, only with the block idle.
	task automatic write_gate(input logic [gptt_pkg::RADIUS_W-1:0] radius);
		drain();
		repeat (8) @(posedge clk);
		cfg_data <= radius;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		gate_model = radius;
		gate_writes++;
	endtask

	initial begin
		logic [gptt_pkg::RADIUS_W-1:0] phase_gate;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset gate 160: opposite corners, exact match at the top, floor average
		// at the bottom, gate edge just inside and exactly on it, negative halves.
		queue_det(-32768, -32768);
		queue_det(32767, 32767);
		queue_det(32767, 32767);
		queue_det(-32767, -32768);
		queue_det(0, 0);
		queue_det(159, 0);
		queue_det(239, 0);
		queue_det(-1, -1);

		// Zero gate: even an identical point opens a new track; fill, then drop.
		write_gate('0);
		queue_det(39, -1);
		repeat (11)
			pending_dets = {pending_dets, make_detection()};
		queue_det(32767, -32768);
		queue_det(-32768, 32767);

		// Random phases over a spread of gates, extremes included.
		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				0: phase_gate = 15'd32767;
				1: phase_gate = 15'($urandom_range(8, 400));
				2: phase_gate = 15'd1;
				3: phase_gate = 15'd160;
				4: phase_gate = 15'($urandom_range(401, 8000));
				5: phase_gate = 15'($urandom_range(0, 32767));
				default: phase_gate = '0;
			endcase
			write_gate(phase_gate);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				while (pending_dets.size() >= 3)
					@(negedge clk);
				pending_dets = {pending_dets, make_detection()};
			end
		end

		drain();
		repeat (60) @(posedge clk);
		if (awaited_results.size() > 0) begin
			mismatch_count++;
			$display("%0t ns: %0d results never arrived", $time, awaited_results.size());
		end

		$display("Sent %0d detections over %0d gate settings: %0d matched, %0d opened, %0d dropped.",
			sent_count, gate_writes, matched_count, opened_count, dropped_count);
		if (mismatch_count == 0)
			$display("gated_position_track_table test passed");
		else
			$display("gated_position_track_table test failed");
		$finish;
	end

endmodule
